FILE: src/accept_encoding_matcher_unit_assert.svh
// assertion macros shared by the rtl files
// each expects signals named clk and rst in the enclosing scope
`ifndef ACCEPT_ENCODING_MATCHER_UNIT_ASSERT_SVH
`define ACCEPT_ENCODING_MATCHER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define AEM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define AEM_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`else

`define AEM_ASSERT(label, prop, msg)

`define AEM_ASSERT_NEXT(label, cond, conseq, msg)

`endif

`endif

FILE: src/aem_pkg.sv
package aem_pkg;

  typedef enum logic [8:0] {
    PH_SKIP  = 9'b000000001,
    PH_ELEM  = 9'b000000010,
    PH_NAME  = 9'b000000100,
    PH_GAP   = 9'b000001000,
    PH_PARAM = 9'b000010000,
    PH_SAWQ  = 9'b000100000,
    PH_QVAL  = 9'b001000000,
    PH_QZERO = 9'b010000000,
    PH_QZDOT = 9'b100000000
  } aem_phase_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       end_of_header;
  } aem_item_t;

  typedef enum logic {
    REG_CODING_NAME   = 1'b0,
    REG_CODING_LENGTH = 1'b1
  } aem_reg_t;

  localparam logic [63:0] CODING_NAME_RESET   = 64'd1885960807;
  localparam logic [3:0]  CODING_LENGTH_RESET = 4'd4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LQ    = 8'h71;
  localparam logic [7:0] CH_UQ    = 8'h51;

endpackage

FILE: src/aem_in_if.sv
interface aem_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic       end_of_header;

  modport source (output valid, output header_byte, output end_of_header, input ready);
  modport sink (input valid, input header_byte, input end_of_header, output ready);
endinterface

FILE: src/aem_out_if.sv
interface aem_out_if;
  logic valid;
  logic ready;
  logic coding_wanted;

  modport source (output valid, output coding_wanted, input ready);
  modport sink (input valid, input coding_wanted, output ready);
endinterface

FILE: src/aem_cfg_if.sv
interface aem_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/accept_encoding_matcher_unit.sv
// Accept-Encoding matcher: takes one header byte per transaction and, on the
// byte flagged end_of_header, returns one verdict telling whether the coding
// name set in the configuration registers is wanted by the client. A byte can
// be accepted every cycle; it is registered, parsed by a state step,
// and the verdict lands in an output register when the last byte moves on, so a
// result waits there until taken. Input stalls only when a last byte is waiting
// and the output register still holds a verdict that has not been taken.
// Configuration writes are accepted at any time and must be made while idle.
module accept_encoding_matcher_unit
  import aem_pkg::*;
#(
  parameter int MAX_NAME_CHARS = 8
) (
  input  logic    clk,
  input  logic    rst,
  aem_in_if.sink  header,
  aem_out_if.source verdict,
  aem_cfg_if.sink cfg
);

  `include "accept_encoding_matcher_unit_assert.svh"

  localparam int         NAME_BITS = MAX_NAME_CHARS * 8;
  localparam logic [3:0] MAX_LEN   = 4'(MAX_NAME_CHARS);

  logic [NAME_BITS-1:0] coding_name;
  logic [3:0]           coding_length;
  logic [3:0]           name_len;

  logic      item_valid;
  aem_item_t item;
  logic      advance;
  logic      parsed_verdict;

  logic out_valid;
  logic out_wanted;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coding_name   <= CODING_NAME_RESET[NAME_BITS-1:0];
      coding_length <= CODING_LENGTH_RESET;
    end else if (cfg.valid) begin
      unique case (aem_reg_t'(cfg.index))
        REG_CODING_NAME:   coding_name   <= cfg.data[NAME_BITS-1:0];
        REG_CODING_LENGTH: coding_length <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

  assign name_len = (coding_length > MAX_LEN) ? MAX_LEN : coding_length;

  // a last byte may only move on when the output register is free or being read
  assign advance      = item_valid && (!item.end_of_header || !out_valid || verdict.ready);
  assign header.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (header.ready) begin
      item_valid <= header.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (header.ready && header.valid) begin
      item.header_byte   <= header.header_byte;
      item.end_of_header <= header.end_of_header;
    end
  end

  aem_parser #(
    .MAX_NAME_CHARS(MAX_NAME_CHARS)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .item     (item),
    .name     (coding_name),
    .name_len (name_len),
    .verdict  (parsed_verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && item.end_of_header) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item.end_of_header) begin
      out_wanted <= parsed_verdict;
    end
  end

  assign verdict.valid         = out_valid;
  assign verdict.coding_wanted = out_wanted;

  `AEM_ASSERT_NEXT(a_last_gives_result, advance && item.end_of_header, out_valid, "last byte produced no result")
  `AEM_ASSERT(a_stall_reason, header.ready || (item_valid && item.end_of_header && out_valid && !verdict.ready), "input stalled without a pending result")
  `AEM_ASSERT_NEXT(a_result_held, out_valid && !verdict.ready, out_valid && $stable(out_wanted), "pending result lost or changed")

endmodule

FILE: src/aem_parser.sv
module aem_parser
  import aem_pkg::*;
#(
  parameter int MAX_NAME_CHARS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  aem_item_t                   item,
  input  logic [MAX_NAME_CHARS*8-1:0] name,
  input  logic [3:0]                  name_len,
  output logic                        verdict
);

  `include "accept_encoding_matcher_unit_assert.svh"

  aem_phase_t phase, phase_next;
  logic [3:0] name_position, name_position_next;
  logic       verdict_fixed, verdict_fixed_next;
  logic       verdict_value, verdict_value_next;
  logic       header_ended, header_ended_next;

  logic [7:0] name_chars [MAX_NAME_CHARS];
  logic [3:0] cmp_pos;
  logic [7:0] want;

  function automatic logic [7:0] fold(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? 8'(c + 8'd32) : c;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  // verdict when the header ends in the given phase
  function automatic logic end_verdict(input aem_phase_t ph, input logic [3:0] pos,
                                       input logic [3:0] len);
    logic r;
    r = 1'b0;
    unique case (ph)
      PH_NAME: r = (pos >= len);
      PH_GAP, PH_PARAM, PH_SAWQ, PH_QVAL, PH_QZDOT: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < MAX_NAME_CHARS; i++) begin
      name_chars[i] = name[i*8 +: 8];
    end
    // a byte that opens a new element is compared with the first character
    cmp_pos = (phase == PH_NAME) ? name_position : 4'd0;
    want = CH_NUL;
    for (int i = 0; i < MAX_NAME_CHARS; i++) begin
      if (cmp_pos == 4'(i)) begin
        want = name_chars[i];
      end
    end
  end

  // the name compare is shared by the name arm and the arm that opens an element
  logic [7:0] c;
  logic       do_name;

  always_comb begin
    c = item.header_byte;
    phase_next         = phase;
    name_position_next = name_position;
    verdict_fixed_next = verdict_fixed;
    verdict_value_next = verdict_value;
    header_ended_next  = header_ended;
    do_name            = 1'b0;

    if (!header_ended) begin
      if (c == CH_NUL) begin
        header_ended_next = 1'b1;
        if (!verdict_fixed) begin
          verdict_fixed_next = 1'b1;
          verdict_value_next = end_verdict(phase, name_position, name_len);
        end
      end else if (!verdict_fixed) begin
        unique case (phase)
          PH_ELEM: begin
            if (c == CH_COMMA) phase_next = PH_SKIP;
          end
          PH_NAME: do_name = 1'b1;
          PH_GAP: begin
            if (!is_blank(c)) begin
              if (c == CH_SEMI) begin
                phase_next = PH_PARAM;
              end else begin
                verdict_fixed_next = 1'b1;
                verdict_value_next = 1'b1;
              end
            end
          end
          PH_PARAM: begin
            if (c == CH_COMMA) begin
              verdict_fixed_next = 1'b1;
              verdict_value_next = 1'b1;
            end else if (c == CH_LQ || c == CH_UQ) begin
              phase_next = PH_SAWQ;
            end
          end
          PH_SAWQ: begin
            if (c == CH_EQ) begin
              phase_next = PH_QVAL;
            end else if (c == CH_COMMA) begin
              verdict_fixed_next = 1'b1;
              verdict_value_next = 1'b1;
            end else if (c != CH_LQ && c != CH_UQ) begin
              phase_next = PH_PARAM;
            end
          end
          PH_QVAL: begin
            if (!is_blank(c)) begin
              if (c == CH_ZERO) begin
                phase_next = PH_QZERO;
              end else begin
                verdict_fixed_next = 1'b1;
                verdict_value_next = 1'b1;
              end
            end
          end
          PH_QZERO: begin
            if (c == CH_COMMA || c == CH_SEMI || is_blank(c)) begin
              verdict_fixed_next = 1'b1;
              verdict_value_next = 1'b0;
            end else if (c == CH_DOT) begin
              phase_next = PH_QZDOT;
            end else begin
              verdict_fixed_next = 1'b1;
              verdict_value_next = 1'b1;
            end
          end
          PH_QZDOT: begin
            verdict_fixed_next = 1'b1;
            verdict_value_next = (c != CH_ZERO);
          end
          default: begin
            // between elements, also any stray code
            if (c != CH_COMMA && !is_blank(c)) begin
              phase_next         = PH_NAME;
              name_position_next = '0;
              do_name            = 1'b1;
            end
          end
        endcase

        if (do_name) begin
          if (name_position_next < name_len) begin
            if (want != CH_NUL && fold(c) == fold(want)) begin
              name_position_next = 4'(name_position_next + 4'd1);
            end else begin
              phase_next         = (c == CH_COMMA) ? PH_SKIP : PH_ELEM;
              name_position_next = '0;
            end
          end else if (c == CH_COMMA) begin
            verdict_fixed_next = 1'b1;
            verdict_value_next = 1'b1;
          end else if (c == CH_SEMI) begin
            phase_next = PH_PARAM;
          end else if (is_blank(c)) begin
            phase_next = PH_GAP;
          end else begin
            phase_next         = PH_ELEM;
            name_position_next = '0;
          end
        end
      end
    end

    // apply the header end after the last byte
    if (item.end_of_header && !header_ended_next && !verdict_fixed_next) begin
      verdict_value_next = end_verdict(phase_next, name_position_next, name_len);
    end
  end

  assign verdict = verdict_value_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SKIP;
      name_position <= '0;
      verdict_fixed <= 1'b0;
      verdict_value <= 1'b0;
      header_ended  <= 1'b0;
    end else if (step) begin
      if (item.end_of_header) begin
        phase         <= PH_SKIP;
        name_position <= '0;
        verdict_fixed <= 1'b0;
        verdict_value <= 1'b0;
        header_ended  <= 1'b0;
      end else begin
        phase         <= phase_next;
        name_position <= name_position_next;
        verdict_fixed <= verdict_fixed_next;
        verdict_value <= verdict_value_next;
        header_ended  <= header_ended_next;
      end
    end
  end

  `AEM_ASSERT_NEXT(a_clear_after_last, step && item.end_of_header, phase == PH_SKIP && !verdict_fixed && !header_ended, "parse state not cleared after last byte")
  `AEM_ASSERT_NEXT(a_verdict_holds, verdict_fixed && !(step && item.end_of_header), verdict_fixed && $stable(verdict_value), "fixed verdict changed within a header")
  `AEM_ASSERT(a_ended_fixes, !header_ended || verdict_fixed, "header ended with verdict still open")

endmodule
